[design/pid_dom_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID derivative-on-measurement package
// Shared widths, register map, payload and control types, fixed-point helpers.
// ----------------------------------------------------------------------------
package pid_dom_pkg;

    // Sample and gain formats
    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int ACC_FRAC       = 8;
    localparam int GAIN_W         = 16;
    localparam int LIMIT_W        = 16;
    localparam int DRIVE_W        = 16;
    localparam int TIME_W         = 32;

    // Derived arithmetic widths
    localparam int DIFF_W   = SAMPLE_BITS + 1;
    localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
    localparam int UP_SHIFT = (ACC_FRAC > GAIN_FRAC_BITS) ? ACC_FRAC - GAIN_FRAC_BITS : 0;
    localparam int DN_SHIFT = (GAIN_FRAC_BITS > ACC_FRAC) ? GAIN_FRAC_BITS - ACC_FRAC : 0;
    localparam int TERM_W   = PROD_W + UP_SHIFT;
    localparam int LIM_W    = LIMIT_W + ACC_FRAC;
    localparam int WIDE_W   = ((TERM_W > LIM_W) ? TERM_W : LIM_W) + 2;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_LOW    = 3'd3,
        REG_OUT_HIGH   = 3'd4,
        REG_PERIOD_MS  = 3'd5
    } reg_idx_t;

    localparam logic signed [LIMIT_W-1:0] OUT_LOW_RST  = -16'sd255;
    localparam logic signed [LIMIT_W-1:0] OUT_HIGH_RST = 16'sd255;

    typedef struct packed {
        logic        [GAIN_W-1:0]  prop_gain;
        logic        [GAIN_W-1:0]  integ_gain;
        logic        [GAIN_W-1:0]  deriv_gain;
        logic signed [LIMIT_W-1:0] out_low;
        logic signed [LIMIT_W-1:0] out_high;
        logic        [TIME_W-1:0]  period_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] target;
        logic signed [SAMPLE_BITS-1:0] measured;
        logic        [TIME_W-1:0]      now_ms;
    } in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      updated;
    } res_t;

    // Gain times signed integer, aligned to ACC_FRAC fraction bits
    function automatic logic signed [TERM_W-1:0] gain_mul(
        input logic        [GAIN_W-1:0] gain,
        input logic signed [DIFF_W-1:0] x
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [TERM_W-1:0] term;
        prod = $signed({1'b0, gain}) * x;
        term = TERM_W'(prod);
        term = term <<< UP_SHIFT;
        return term >>> DN_SHIFT;
    endfunction

    // Clamp to the output limits; crossed limits give hi above hi, else lo
    function automatic logic signed [LIM_W-1:0] clamp_lim(
        input logic signed [WIDE_W-1:0]  v,
        input logic signed [LIMIT_W-1:0] lo,
        input logic signed [LIMIT_W-1:0] hi
    );
        logic signed [LIM_W-1:0]  hi_s;
        logic signed [LIM_W-1:0]  lo_s;
        hi_s = $signed({hi, {ACC_FRAC{1'b0}}});
        lo_s = $signed({lo, {ACC_FRAC{1'b0}}});
        if (v > WIDE_W'(hi_s)) begin
            return hi_s;
        end else if (v < WIDE_W'(lo_s)) begin
            return lo_s;
        end
        return v[LIM_W-1:0];
    endfunction

endpackage

[design/pid_step_deriv_on_measurement.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller step, derivative on measurement
// Fixed-point PID with sample-period gating, output clamping and APB setup.
// ----------------------------------------------------------------------------
// Each input beat carries a setpoint, a measurement and a wrapping millisecond
// timestamp, and yields exactly one result beat. The controller recomputes on
// the first beat after reset and whenever the wrapped time since the last
// recomputation reaches period_ms; otherwise it repeats the held drive with
// updated low. Gains are unsigned Q8.8; the integral and the sum keep 8
// fraction bits and are clamped to [out_low, out_high], and drive is the floor
// of the clamped sum. Throughput is one beat per clock while m_ready does not
// hold the output: the beat is captured in an input register, the three gain
// multiplies, integral update and clamps run in one combinational pass, and
// the result lands in an output register that drives m_valid. s_ready stays
// high while the input register is empty or its beat can move into the output
// register; with m_ready low and both registers full it drops, and it follows
// m_ready within the same cycle. Write configuration only while no beat is in
// flight.
// ----------------------------------------------------------------------------
module pid_step_deriv_on_measurement (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // Sample beats in
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [pid_dom_pkg::SAMPLE_BITS-1:0] s_target,
    input  logic signed [pid_dom_pkg::SAMPLE_BITS-1:0] s_measured,
    input  logic        [pid_dom_pkg::TIME_W-1:0]      s_now_ms,

    // Result beats out
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pid_dom_pkg::DRIVE_W-1:0]  m_drive,
    output logic                                    m_updated,

    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic        [pid_dom_pkg::PADDR_W-1:0]  paddr,
    input  logic        [pid_dom_pkg::PDATA_W-1:0]  pwdata,
    output logic        [pid_dom_pkg::PDATA_W-1:0]  prdata,
    output logic                                    pready
);

    pid_dom_pkg::cfg_t cfg;
    pid_dom_pkg::in_t  in_reg;
    pid_dom_pkg::in_t  in_next;
    pid_dom_pkg::res_t res;
    pid_dom_pkg::res_t out_reg;
    pid_dom_pkg::res_t out_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              advance;
    logic              take_in;

    pid_dom_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pid_dom_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Output slot is free when empty or draining this cycle
    assign out_free = !out_valid_reg || m_ready;
    // Move the captured beat through the core into the output register
    assign advance  = in_valid_reg && out_free;
    // Input slot is free when empty or advancing this cycle
    assign s_ready  = !in_valid_reg || out_free;
    assign take_in  = s_valid && s_ready;

    always_comb begin
        in_next        = in_reg;
        in_valid_next  = in_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // Drain the result first, then refill from the core
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_next       = res;
            out_valid_next = 1'b1;
            in_valid_next  = 1'b0;
        end
        // Capture a new beat; hold the previous one otherwise
        if (take_in) begin
            in_next.target   = s_target;
            in_next.measured = s_measured;
            in_next.now_ms   = s_now_ms;
            in_valid_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_drive   = out_reg.drive;
    assign m_updated = out_reg.updated;

endmodule

[design/pid_dom_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID configuration registers
// APB-style register file holding gains, output limits and sample period.
// ----------------------------------------------------------------------------
module pid_dom_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pid_dom_pkg::PADDR_W-1:0]  paddr,
    input  logic [pid_dom_pkg::PDATA_W-1:0]  pwdata,
    output logic [pid_dom_pkg::PDATA_W-1:0]  prdata,
    output logic                             pready,
    output pid_dom_pkg::cfg_t                cfg
);

    pid_dom_pkg::cfg_t     cfg_reg;
    pid_dom_pkg::cfg_t     cfg_next;
    pid_dom_pkg::reg_idx_t idx;
    logic                  wr_en;

    assign idx    = pid_dom_pkg::reg_idx_t'(paddr[pid_dom_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                pid_dom_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain  = pwdata[pid_dom_pkg::GAIN_W-1:0];
                pid_dom_pkg::REG_INTEG_GAIN:
                    cfg_next.integ_gain = pwdata[pid_dom_pkg::GAIN_W-1:0];
                pid_dom_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = pwdata[pid_dom_pkg::GAIN_W-1:0];
                pid_dom_pkg::REG_OUT_LOW:
                    cfg_next.out_low    = $signed(pwdata[pid_dom_pkg::LIMIT_W-1:0]);
                pid_dom_pkg::REG_OUT_HIGH:
                    cfg_next.out_high   = $signed(pwdata[pid_dom_pkg::LIMIT_W-1:0]);
                pid_dom_pkg::REG_PERIOD_MS:
                    cfg_next.period_ms  = pwdata[pid_dom_pkg::TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pid_dom_pkg::REG_PROP_GAIN:  prdata = pid_dom_pkg::PDATA_W'(cfg_reg.prop_gain);
            pid_dom_pkg::REG_INTEG_GAIN: prdata = pid_dom_pkg::PDATA_W'(cfg_reg.integ_gain);
            pid_dom_pkg::REG_DERIV_GAIN: prdata = pid_dom_pkg::PDATA_W'(cfg_reg.deriv_gain);
            pid_dom_pkg::REG_OUT_LOW:    prdata = pid_dom_pkg::PDATA_W'(cfg_reg.out_low);
            pid_dom_pkg::REG_OUT_HIGH:   prdata = pid_dom_pkg::PDATA_W'(cfg_reg.out_high);
            pid_dom_pkg::REG_PERIOD_MS:  prdata = pid_dom_pkg::PDATA_W'(cfg_reg.period_ms);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain  <= '0;
            cfg_reg.integ_gain <= '0;
            cfg_reg.deriv_gain <= '0;
            cfg_reg.out_low    <= pid_dom_pkg::OUT_LOW_RST;
            cfg_reg.out_high   <= pid_dom_pkg::OUT_HIGH_RST;
            cfg_reg.period_ms  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/pid_dom_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID update core
// Controller state plus the combinational update math for one sample.
// ----------------------------------------------------------------------------
module pid_dom_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  pid_dom_pkg::in_t  item,
    input  pid_dom_pkg::cfg_t cfg,
    output pid_dom_pkg::res_t res
);

    // Controller state
    logic signed [pid_dom_pkg::LIM_W-1:0]       integ_reg;
    logic signed [pid_dom_pkg::LIM_W-1:0]       integ_next;
    logic signed [pid_dom_pkg::SAMPLE_BITS-1:0] prev_meas_reg;
    logic signed [pid_dom_pkg::DRIVE_W-1:0]     held_reg;
    logic signed [pid_dom_pkg::DRIVE_W-1:0]     held_next;
    logic        [pid_dom_pkg::TIME_W-1:0]      last_ms_reg;
    logic                                       primed_reg;

    logic        [pid_dom_pkg::TIME_W-1:0] elapsed;
    logic                                  recompute;
    logic signed [pid_dom_pkg::DIFF_W-1:0] err;
    logic signed [pid_dom_pkg::DIFF_W-1:0] dmeas;
    logic signed [pid_dom_pkg::TERM_W-1:0] p_term;
    logic signed [pid_dom_pkg::TERM_W-1:0] i_term;
    logic signed [pid_dom_pkg::TERM_W-1:0] d_term;
    logic signed [pid_dom_pkg::WIDE_W-1:0] integ_sum;
    logic signed [pid_dom_pkg::WIDE_W-1:0] pid_sum;
    logic signed [pid_dom_pkg::LIM_W-1:0]  pid_clamped;

    assign elapsed   = item.now_ms - last_ms_reg;
    assign recompute = !primed_reg || (elapsed >= cfg.period_ms);

    assign err   = pid_dom_pkg::DIFF_W'(item.target) - pid_dom_pkg::DIFF_W'(item.measured);
    assign dmeas = pid_dom_pkg::DIFF_W'(item.measured) - pid_dom_pkg::DIFF_W'(prev_meas_reg);

    assign p_term = pid_dom_pkg::gain_mul(cfg.prop_gain, err);
    assign i_term = pid_dom_pkg::gain_mul(cfg.integ_gain, err);
    assign d_term = pid_dom_pkg::gain_mul(cfg.deriv_gain, dmeas);

    assign integ_sum  = pid_dom_pkg::WIDE_W'(integ_reg) + pid_dom_pkg::WIDE_W'(i_term);
    assign integ_next = pid_dom_pkg::clamp_lim(integ_sum, cfg.out_low, cfg.out_high);

    assign pid_sum = pid_dom_pkg::WIDE_W'(p_term) + pid_dom_pkg::WIDE_W'(integ_next)
                   - pid_dom_pkg::WIDE_W'(d_term);
    assign pid_clamped = pid_dom_pkg::clamp_lim(pid_sum, cfg.out_low, cfg.out_high);

    // Floor of the clamped sum: drop the fraction bits
    assign held_next = pid_clamped[pid_dom_pkg::LIM_W-1:pid_dom_pkg::ACC_FRAC];

    assign res.drive   = recompute ? held_next : held_reg;
    assign res.updated = recompute;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            prev_meas_reg <= '0;
            held_reg      <= '0;
            last_ms_reg   <= '0;
            primed_reg    <= 1'b0;
        end else if (advance && recompute) begin
            integ_reg     <= integ_next;
            prev_meas_reg <= item.measured;
            held_reg      <= held_next;
            last_ms_reg   <= item.now_ms;
            primed_reg    <= 1'b1;
        end
    end

endmodule
